[rtl/core/tccw_pkg.sv]
// Shared types, step numbers and the microcode table of the text console writer.
// No dependencies; the sequencer, the datapath and the top level import it.
package tccw_pkg;

  localparam int unsigned StepW = 4;
  typedef logic [StepW-1:0] step_t;

  localparam logic [7:0] NewlineCode = 8'd10;
  localparam logic [7:0] AttrResetVal = 8'd15;

  // Step numbers of the microprogram.
  localparam step_t StClear   = 4'd0;
  localparam step_t StIdle    = 4'd1;
  localparam step_t StAddr    = 4'd2;
  localparam step_t StChkSkip = 4'd3;
  localparam step_t StChkNl   = 4'd4;
  localparam step_t StWrite   = 4'd5;
  localparam step_t StAdvance = 4'd6;
  localparam step_t StScroll  = 4'd7;
  localparam step_t StCopy    = 4'd8;
  localparam step_t StDrain   = 4'd9;
  localparam step_t StClrRow  = 4'd10;
  localparam step_t StFinish  = 4'd11;
  localparam step_t StEmit    = 4'd12;
  localparam step_t StRead    = 4'd13;

  typedef enum logic [2:0] {
    COND_ALWAYS    = 3'd0,
    COND_START     = 3'd1,
    COND_READ      = 3'd2,
    COND_SKIP      = 3'd3,
    COND_NL        = 3'd4,
    COND_SCROLL    = 3'd5,
    COND_PTR_LAST  = 3'd6,
    COND_COPY_LAST = 3'd7
  } cond_e;

  typedef enum logic [3:0] {
    DP_NOP      = 4'd0,
    DP_CLEAR_WR = 4'd1,
    DP_LATCH    = 4'd2,
    DP_ADDR     = 4'd3,
    DP_WRITE    = 4'd4,
    DP_ADVANCE  = 4'd5,
    DP_SCRL_INI = 4'd6,
    DP_COPY     = 4'd7,
    DP_FINISH   = 4'd8,
    DP_EMIT     = 4'd9
  } dp_op_e;

  // One control word: the datapath action and a conditional jump.
  // The jump is taken when the condition, optionally inverted, holds.
  typedef struct packed {
    dp_op_e op;
    cond_e  cond;
    logic   inv;
    step_t  target;
  } uword_t;

  // Sequencer to datapath.
  typedef struct packed {
    dp_op_e op;
    logic   accept;
  } ctrl_t;

  // Datapath to sequencer.
  typedef struct packed {
    logic is_read;
    logic skip;
    logic is_nl;
    logic scroll;
    logic ptr_last;
    logic copy_last;
  } stat_t;

  function automatic uword_t micro_word(step_t step);
    uword_t w;
    unique case (step)
      StClear:   w = '{DP_CLEAR_WR, COND_PTR_LAST,  1'b1, StClear};
      StIdle:    w = '{DP_LATCH,    COND_START,     1'b1, StIdle};
      StAddr:    w = '{DP_ADDR,     COND_READ,      1'b0, StRead};
      StChkSkip: w = '{DP_NOP,      COND_SKIP,      1'b0, StEmit};
      StChkNl:   w = '{DP_NOP,      COND_NL,        1'b0, StAdvance};
      StWrite:   w = '{DP_WRITE,    COND_ALWAYS,    1'b1, StIdle};
      StAdvance: w = '{DP_ADVANCE,  COND_SCROLL,    1'b1, StFinish};
      StScroll:  w = '{DP_SCRL_INI, COND_ALWAYS,    1'b1, StIdle};
      StCopy:    w = '{DP_COPY,     COND_COPY_LAST, 1'b1, StCopy};
      StDrain:   w = '{DP_NOP,      COND_ALWAYS,    1'b1, StIdle};
      StClrRow:  w = '{DP_CLEAR_WR, COND_PTR_LAST,  1'b1, StClrRow};
      StFinish:  w = '{DP_FINISH,   COND_ALWAYS,    1'b1, StIdle};
      StEmit:    w = '{DP_EMIT,     COND_ALWAYS,    1'b0, StIdle};
      StRead:    w = '{DP_NOP,      COND_ALWAYS,    1'b0, StEmit};
      default:   w = '{DP_NOP,      COND_ALWAYS,    1'b0, StIdle};
    endcase
    return w;
  endfunction

endpackage

[rtl/core/text_console_char_writer.sv]
// Text console writer top level: default attribute register, sequencer and
// datapath. Depends on tccw_pkg, tccw_seq and tccw_datapath.
//
// Usage: after reset the cell memory is cleared one cell a cycle, so busy_o
// stays high until all ROWS*COLUMNS cells are clear, before the first item
// is taken. An item is taken when start_i is high while busy_o is low. A read
// runs the microcode steps Addr, Read and Emit, a print Addr, ChkSkip, ChkNl,
// Write, Advance, Finish and Emit (a newline skips Write, a zero character
// jumps to Emit). A print that scrolls adds Scroll, Copy, Drain and ClrRow,
// one memory word copied or cleared per cycle through the single write port.
// Each result is shown for exactly one cycle on result_valid_o and must be
// taken then; the receiver cannot stall. Write the default attribute only
// while busy_o is low and no result is outstanding.
module text_console_char_writer #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic        operation_i,
  input  logic [7:0]  character_i,
  input  logic [7:0]  attribute_i,
  input  logic        use_position_i,
  input  logic [6:0]  column_i,
  input  logic [4:0]  line_i,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  output logic        result_valid_o,
  output logic [10:0] cursor_index_o,
  output logic [7:0]  cell_character_o,
  output logic [7:0]  cell_attribute_o,
  output logic        scrolled_o
);
  import tccw_pkg::*;

  ctrl_t      ctrl;
  stat_t      stat;
  logic [7:0] default_attr_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      default_attr_q <= AttrResetVal;
    end else if (cfg_valid_i && cfg_ready_o) begin
      default_attr_q <= cfg_data_i;
    end
  end

  tccw_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start_i),
    .stat_i  (stat),
    .ctrl_o  (ctrl),
    .busy_o  (busy_o)
  );

  tccw_datapath #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .stat_o           (stat),
    .default_attr_i   (default_attr_q),
    .operation_i      (operation_i),
    .character_i      (character_i),
    .attribute_i      (attribute_i),
    .use_position_i   (use_position_i),
    .column_i         (column_i),
    .line_i           (line_i),
    .result_valid_o   (result_valid_o),
    .cursor_index_o   (cursor_index_o),
    .cell_character_o (cell_character_o),
    .cell_attribute_o (cell_attribute_o),
    .scrolled_o       (scrolled_o)
  );

endmodule

[rtl/core/tccw_seq.sv]
// Microcode sequencer: step counter, control table lookup and jump logic.
// Depends on tccw_pkg for the control word, condition and status types.
module tccw_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start_i,
  input  tccw_pkg::stat_t stat_i,
  output tccw_pkg::ctrl_t ctrl_o,
  output logic            busy_o
);
  import tccw_pkg::*;

  step_t  step_q, step_d;
  uword_t word;
  logic   cond_hit;
  logic   idle;

  assign word = micro_word(step_q);
  assign idle = (word.op == DP_LATCH);

  always_comb begin
    unique case (word.cond)
      COND_ALWAYS:    cond_hit = 1'b1;
      COND_START:     cond_hit = start_i;
      COND_READ:      cond_hit = stat_i.is_read;
      COND_SKIP:      cond_hit = stat_i.skip;
      COND_NL:        cond_hit = stat_i.is_nl;
      COND_SCROLL:    cond_hit = stat_i.scroll;
      COND_PTR_LAST:  cond_hit = stat_i.ptr_last;
      COND_COPY_LAST: cond_hit = stat_i.copy_last;
      default:        cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    if (cond_hit ^ word.inv) begin
      step_d = word.target;
    end else begin
      step_d = step_q + step_t'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= StClear;
    end else begin
      step_q <= step_d;
    end
  end

  assign busy_o        = !idle;
  assign ctrl_o.op     = word.op;
  assign ctrl_o.accept = idle && start_i;

endmodule

[rtl/core/tccw_datapath.sv]
// Datapath of the console writer: item registers, cursor, cell memory with
// scroll copy pipeline, and the result registers. Depends on tccw_pkg.
module tccw_datapath #(
  parameter int unsigned COLUMNS = 80,
  parameter int unsigned ROWS    = 25
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  tccw_pkg::ctrl_t ctrl_i,
  output tccw_pkg::stat_t stat_o,
  input  logic [7:0]      default_attr_i,
  input  logic            operation_i,
  input  logic [7:0]      character_i,
  input  logic [7:0]      attribute_i,
  input  logic            use_position_i,
  input  logic [6:0]      column_i,
  input  logic [4:0]      line_i,
  output logic            result_valid_o,
  output logic [10:0]     cursor_index_o,
  output logic [7:0]      cell_character_o,
  output logic [7:0]      cell_attribute_o,
  output logic            scrolled_o
);
  import tccw_pkg::*;

  localparam int unsigned Cells  = ROWS * COLUMNS;
  localparam int unsigned ColW   = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned RowW   = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int unsigned AddrW  = $clog2(Cells);

  // Item registers.
  logic            is_read_q;
  logic [7:0]      char_q;
  logic [7:0]      attr_q;
  logic            scroll_q, scroll_d;
  logic [ColW-1:0] tgt_col_q, tgt_col_d;
  logic [RowW-1:0] tgt_row_q, tgt_row_d;
  logic [AddrW-1:0] addr_q;

  // Cursor.
  logic [ColW-1:0]  cur_col_q;
  logic [RowW-1:0]  cur_row_q;
  logic [AddrW-1:0] cur_idx_q;

  // Cell memory and the sweep pointer used for clearing and scrolling.
  logic [15:0]      mem_q [Cells];
  logic [15:0]      rdata_q;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic             pend_q;
  logic [AddrW-1:0] pend_addr_q;
  logic [AddrW-1:0] rd_addr;
  logic             we;
  logic [AddrW-1:0] waddr;
  logic [15:0]      wdata;

  logic [ColW-1:0]  in_col;
  logic [RowW-1:0]  in_row;
  logic [AddrW-1:0] lin_idx;
  logic             col_last;
  logic             row_last;
  logic             is_nl;
  logic [16:0]      cur_idx_ext;

  // Out-of-range positions saturate to the last column or row.
  assign in_col = (9'(column_i) >= 9'(COLUMNS)) ? ColW'(COLUMNS - 1) : ColW'(column_i);
  assign in_row = (9'(line_i) >= 9'(ROWS)) ? RowW'(ROWS - 1) : RowW'(line_i);

  assign lin_idx  = AddrW'(tgt_row_q) * AddrW'(COLUMNS) + AddrW'(tgt_col_q);
  assign col_last = (tgt_col_q == ColW'(COLUMNS - 1));
  assign row_last = (tgt_row_q == RowW'(ROWS - 1));
  assign is_nl    = (char_q == NewlineCode);

  assign stat_o.is_read   = is_read_q;
  assign stat_o.skip      = !is_read_q && (char_q == 8'd0);
  assign stat_o.is_nl     = is_nl;
  assign stat_o.scroll    = (is_nl || col_last) && row_last;
  assign stat_o.ptr_last  = (ptr_q == AddrW'(Cells - 1));
  assign stat_o.copy_last = (ptr_q == AddrW'(Cells - COLUMNS - 1));

  // During the copy loop the row below is read while the previous word is
  // written back one row up.
  assign rd_addr = (ctrl_i.op == DP_COPY) ? AddrW'(ptr_q + AddrW'(COLUMNS)) : addr_q;

  always_comb begin
    we    = 1'b0;
    waddr = addr_q;
    wdata = {attr_q, char_q};
    if (pend_q) begin
      we    = 1'b1;
      waddr = pend_addr_q;
      wdata = rdata_q;
    end else if (ctrl_i.op == DP_CLEAR_WR) begin
      we    = 1'b1;
      waddr = ptr_q;
      wdata = 16'd0;
    end else if (ctrl_i.op == DP_WRITE) begin
      we    = 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rdata_q <= mem_q[rd_addr];
  end

  always_comb begin
    ptr_d = ptr_q;
    unique case (ctrl_i.op)
      DP_CLEAR_WR, DP_COPY: ptr_d = ptr_q + AddrW'(1);
      DP_SCRL_INI:          ptr_d = '0;
      default:              ptr_d = ptr_q;
    endcase
  end

  always_comb begin
    tgt_col_d = tgt_col_q;
    tgt_row_d = tgt_row_q;
    scroll_d  = scroll_q;
    if (ctrl_i.accept) begin
      scroll_d = 1'b0;
      if (operation_i || use_position_i) begin
        tgt_col_d = in_col;
        tgt_row_d = in_row;
      end else begin
        tgt_col_d = cur_col_q;
        tgt_row_d = cur_row_q;
      end
    end else if (ctrl_i.op == DP_ADVANCE) begin
      // A newline acts as a print in the last column of its row.
      if (is_nl || col_last) begin
        tgt_col_d = '0;
        if (row_last) begin
          scroll_d = 1'b1;
        end else begin
          tgt_row_d = tgt_row_q + RowW'(1);
        end
      end else begin
        tgt_col_d = tgt_col_q + ColW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    tgt_col_q <= tgt_col_d;
    tgt_row_q <= tgt_row_d;
    if (ctrl_i.accept) begin
      is_read_q <= operation_i;
      char_q    <= character_i;
      attr_q    <= (attribute_i == 8'd0) ? default_attr_i : attribute_i;
    end
    if (ctrl_i.op == DP_ADDR) begin
      addr_q <= lin_idx;
    end
    if (ctrl_i.op == DP_COPY) begin
      pend_addr_q <= ptr_q;
    end
  end

  assign cur_idx_ext = 17'(cur_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ptr_q            <= '0;
      pend_q           <= 1'b0;
      scroll_q         <= 1'b0;
      cur_col_q        <= '0;
      cur_row_q        <= '0;
      cur_idx_q        <= '0;
      result_valid_o   <= 1'b0;
      cursor_index_o   <= '0;
      cell_character_o <= '0;
      cell_attribute_o <= '0;
      scrolled_o       <= 1'b0;
    end else begin
      ptr_q          <= ptr_d;
      pend_q         <= (ctrl_i.op == DP_COPY);
      scroll_q       <= scroll_d;
      result_valid_o <= (ctrl_i.op == DP_EMIT);
      if (ctrl_i.op == DP_FINISH) begin
        cur_col_q <= tgt_col_q;
        cur_row_q <= tgt_row_q;
        cur_idx_q <= lin_idx;
      end
      if (ctrl_i.op == DP_EMIT) begin
        cursor_index_o   <= cur_idx_ext[10:0];
        cell_character_o <= is_read_q ? rdata_q[7:0] : 8'd0;
        cell_attribute_o <= is_read_q ? rdata_q[15:8] : 8'd0;
        scrolled_o       <= scroll_q;
      end
    end
  end

endmodule
